>>> sv/hftq_pkg.sv
// shared types and constants for the heightfield triangle height query block
// no dependencies; every other file of the block but hftq_ram imports this package
package hftq_pkg;

    localparam int H_W      = 16;       // height and position width, signed q7.8
    localparam int IDX_W    = 5;        // grid index field width
    localparam int FRAC_W   = 8;        // fraction bits of q7.8
    localparam int CELL_Q8  = 1280;     // 5 units in q8
    localparam int HALF_Q8  = 640;      // half a cell in q8
    localparam int H_MAX    = 2 ** (H_W - 1) - 1;
    localparam int H_MIN    = -(2 ** (H_W - 1));

    // datapath widths
    localparam int D_W      = H_W + 1;              // height difference
    localparam int F_W      = 11;                   // weight, 0..1280
    localparam int P_W      = D_W + F_W + 1;        // difference times weight
    localparam int N_W      = P_W + 1;              // sum of both products
    localparam int V_W      = N_W - FRAC_W;         // magnitude after dropping the q8 part

    // divide by 5 through a reciprocal, exact over the ranges used here
    localparam int CELL_RCP    = 3277;
    localparam int CELL_RCP_W  = 12;
    localparam int CELL_RCP_SH = 14;
    localparam int NUM_RCP     = 6710887;
    localparam int NUM_RCP_W   = 23;
    localparam int NUM_RCP_SH  = 25;
    localparam int Q_W         = V_W + NUM_RCP_W - NUM_RCP_SH;
    localparam int S_W         = Q_W + 2;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    // bit 0 steps x by one, bit 1 steps z by one
    typedef enum logic [1:0] {
        CORNER_H0 = 2'b00,
        CORNER_H1 = 2'b01,
        CORNER_H2 = 2'b10,
        CORNER_H3 = 2'b11
    } corner_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CELL,
        S_FRAC,
        S_RD1,
        S_RD2,
        S_RD3,
        S_DIFF,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_ABS,
        S_RCP,
        S_FIN
    } state_t;

    typedef struct packed {
        logic    accept;
        logic    cell_en;
        logic    frac_en;
        logic    rd_en;
        corner_t rd_corner;
        logic    cap_en;
        corner_t cap_corner;
        logic    diff_en;
        logic    mul_en;
        logic    mul_second;
        logic    sum_en;
        logic    abs_en;
        logic    rcp_en;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        logic is_query;
        logic in_range;
    } status_t;

endpackage

>>> sv/hftq_ram.sv
// generic memory: one write port, one read port with registered read data
// no dependencies
module hftq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 441
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/hftq_ctrl.sv
// sequencer for the height query: walks one word through its steps
// depends on hftq_pkg; drives the datapath through hftq_pkg::cmd_t
module hftq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  hftq_pkg::status_t st,
    output hftq_pkg::cmd_t   cmd
);

    import hftq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = st.is_query ? S_CELL : S_FIN;
                end
            end
            S_CELL:  state_next = st.in_range ? S_FRAC : S_FIN;
            S_FRAC:  state_next = S_RD1;
            S_RD1:   state_next = S_RD2;
            S_RD2:   state_next = S_RD3;
            S_RD3:   state_next = S_DIFF;
            S_DIFF:  state_next = S_MUL1;
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_SUM;
            S_SUM:   state_next = S_ABS;
            S_ABS:   state_next = S_RCP;
            S_RCP:   state_next = S_FIN;
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:  cmd.accept = in_valid;
            S_CELL:  cmd.cell_en = 1'b1;
            S_FRAC:
            begin
                cmd.frac_en   = 1'b1;
                cmd.rd_en     = 1'b1;
                cmd.rd_corner = CORNER_H0;
            end
            S_RD1:
            begin
                cmd.rd_en      = 1'b1;
                cmd.rd_corner  = CORNER_H1;
                cmd.cap_en     = 1'b1;
                cmd.cap_corner = CORNER_H0;
            end
            S_RD2:
            begin
                cmd.rd_en      = 1'b1;
                cmd.rd_corner  = CORNER_H2;
                cmd.cap_en     = 1'b1;
                cmd.cap_corner = CORNER_H1;
            end
            S_RD3:
            begin
                cmd.rd_en      = 1'b1;
                cmd.rd_corner  = CORNER_H3;
                cmd.cap_en     = 1'b1;
                cmd.cap_corner = CORNER_H2;
            end
            S_DIFF:  cmd.diff_en = 1'b1;
            S_MUL1:  cmd.mul_en = 1'b1;
            S_MUL2:
            begin
                cmd.mul_en     = 1'b1;
                cmd.mul_second = 1'b1;
            end
            S_SUM:   cmd.sum_en = 1'b1;
            S_ABS:   cmd.abs_en = 1'b1;
            S_RCP:   cmd.rcp_en = 1'b1;
            S_FIN:   cmd.load_out = out_free;
            default: cmd = '0;
        endcase
    end

    assign out_valid_next = cmd.load_out || (out_valid_reg && out_stall);
    assign out_valid      = out_valid_reg;
    assign in_stall       = (state_reg != S_IDLE);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("no step after an accepted word");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_valid_reg && out_stall)
        |=> (state_reg == S_FIN && out_valid_reg))
        else $error("result finished over a waiting word");

    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.cell_en, cmd.frac_en, cmd.diff_en, cmd.mul_en,
                  cmd.sum_en, cmd.abs_en, cmd.rcp_en, cmd.load_out}))
        else $error("more than one datapath step at once");

endmodule

>>> sv/hftq_dp.sv
// datapath for the height query: grid memory, cell split, plane interpolation
// depends on hftq_pkg and hftq_ram; steps are enabled by hftq_ctrl
module hftq_dp #(
    parameter int GRID_POINTS = 21
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hftq_pkg::cmd_t                    cmd,
    output hftq_pkg::status_t                 st,
    input  logic                              func,
    input  logic signed [hftq_pkg::H_W-1:0]   pos_x,
    input  logic signed [hftq_pkg::H_W-1:0]   pos_z,
    input  logic [hftq_pkg::IDX_W-1:0]        grid_col,
    input  logic [hftq_pkg::IDX_W-1:0]        grid_row,
    input  logic signed [hftq_pkg::H_W-1:0]   height_value,
    output logic signed [hftq_pkg::H_W-1:0]   height,
    output logic                              in_range
);

    import hftq_pkg::*;

    localparam int HALF  = (GRID_POINTS - 1) * HALF_Q8;
    localparam int SPAN  = (GRID_POINTS - 1) * CELL_Q8;
    localparam int UW    = $clog2(SPAN + 2 ** (H_W - 1)) + 1;
    localparam int VW    = UW - 1 - FRAC_W;
    localparam int PXW   = VW + CELL_RCP_W;
    localparam int CW    = $clog2(GRID_POINTS);
    localparam int DEPTH = GRID_POINTS * GRID_POINTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RPW   = V_W + NUM_RCP_W;

    // position relative to the grid corner
    logic signed [UW-1:0]  u_reg, u_next, w_reg, w_next;
    logic                  qry_reg, inr_reg;
    logic                  range_ok;
    logic [VW-1:0]         vx, vz;
    logic [PXW-1:0]        px, pz;
    logic [CW-1:0]         qx_reg, qx_next, qz_reg, qz_next;
    logic [VW-1:0]         rx, rz;
    logic [F_W-1:0]        dx_reg, dx_next, dz_reg, dz_next;

    // memory ports
    logic                  wr_en;
    logic [AW-1:0]         wr_addr, rd_addr;
    logic signed [H_W-1:0] rd_data;
    logic signed [H_W-1:0] h0_reg, h1_reg, h2_reg;

    // interpolation
    logic                  sel;
    logic signed [D_W-1:0] a_reg, a_next, b_reg, b_next, mul_a;
    logic [F_W-1:0]        f1_reg, f1_next, mul_f;
    logic signed [P_W-1:0] prod, p1_reg, p2_reg;
    logic signed [N_W-1:0] num_reg, num_next;
    logic [N_W-1:0]        mag;
    logic                  neg_reg, neg_next;
    logic [V_W-1:0]        v_reg, v_next;
    logic [RPW-1:0]        rp;
    logic [Q_W-1:0]        q_reg, q_next;
    logic signed [S_W-1:0] qs, sum;
    logic signed [H_W-1:0] sat;
    logic                  hit;
    logic signed [H_W-1:0] height_reg, height_next;
    logic                  in_range_reg, in_range_next;

    hftq_ram #(
        .WIDTH (H_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (height_value),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // writes go straight into memory on the accepting edge
    assign wr_en   = cmd.accept && (func == FUNC_WRITE)
                     && (int'(grid_col) < GRID_POINTS) && (int'(grid_row) < GRID_POINTS);
    assign wr_addr = AW'(int'(grid_col) * GRID_POINTS + int'(grid_row));
    assign rd_addr = AW'((int'(qx_reg) + int'(cmd.rd_corner[0])) * GRID_POINTS
                         + int'(qz_reg) + int'(cmd.rd_corner[1]));

    // cell index and offset: divide by 256 then by 5
    always_comb
    begin
        u_next   = UW'(pos_x) + UW'(HALF);
        w_next   = UW'(HALF) - UW'(pos_z);
        range_ok = !u_reg[UW-1] && (u_reg < UW'(SPAN))
                   && !w_reg[UW-1] && (w_reg < UW'(SPAN));
        vx       = u_reg[UW-2:FRAC_W];
        vz       = w_reg[UW-2:FRAC_W];
        px       = PXW'(vx) * PXW'(CELL_RCP);
        pz       = PXW'(vz) * PXW'(CELL_RCP);
        qx_next  = CW'(px[PXW-1:CELL_RCP_SH]);
        qz_next  = CW'(pz[PXW-1:CELL_RCP_SH]);
        rx       = vx - ((VW'(qx_reg) << 2) + VW'(qx_reg));
        rz       = vz - ((VW'(qz_reg) << 2) + VW'(qz_reg));
        dx_next  = {rx[2:0], u_reg[FRAC_W-1:0]};
        dz_next  = {rz[2:0], w_reg[FRAC_W-1:0]};
    end

    // rd_data holds the far corner when the differences are formed
    always_comb
    begin
        sel     = (({1'b0, dx_reg} + {1'b0, dz_reg}) >= (F_W + 1)'(CELL_Q8));
        a_next  = sel ? D_W'(h2_reg) - D_W'(rd_data) : D_W'(h0_reg) - D_W'(h1_reg);
        b_next  = sel ? D_W'(rd_data) - D_W'(h1_reg) : D_W'(h2_reg) - D_W'(h0_reg);
        f1_next = F_W'(CELL_Q8) - dx_reg;
    end

    // one multiplier shared by both plane terms
    always_comb
    begin
        mul_a    = cmd.mul_second ? b_reg : a_reg;
        mul_f    = cmd.mul_second ? dz_reg : f1_reg;
        prod     = P_W'(mul_a) * P_W'(signed'({1'b0, mul_f}));
        num_next = N_W'(p1_reg) + N_W'(p2_reg);
        neg_next = num_reg[N_W-1];
        mag      = num_reg[N_W-1] ? N_W'(-num_reg) : N_W'(num_reg);
        v_next   = mag[N_W-1:FRAC_W];
        rp       = RPW'(v_reg) * RPW'(NUM_RCP);
        q_next   = rp[RPW-1:NUM_RCP_SH];
    end

    // truncate toward zero, add the base corner, saturate
    always_comb
    begin
        qs  = signed'(S_W'(q_reg));
        sum = S_W'(h1_reg) + (neg_reg ? -qs : qs);
        if (sum > S_W'(H_MAX))
        begin
            sat = H_W'(H_MAX);
        end
        else if (sum < S_W'(H_MIN))
        begin
            sat = H_W'(H_MIN);
        end
        else
        begin
            sat = sum[H_W-1:0];
        end
        hit           = qry_reg && inr_reg;
        height_next   = hit ? sat : '0;
        in_range_next = hit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            u_reg   <= u_next;
            w_reg   <= w_next;
            qry_reg <= func;
            inr_reg <= 1'b0;
        end
        if (cmd.cell_en)
        begin
            qx_reg  <= qx_next;
            qz_reg  <= qz_next;
            inr_reg <= range_ok;
        end
        if (cmd.frac_en)
        begin
            dx_reg <= dx_next;
            dz_reg <= dz_next;
        end
        if (cmd.cap_en && cmd.cap_corner == CORNER_H0)
        begin
            h0_reg <= rd_data;
        end
        if (cmd.cap_en && cmd.cap_corner == CORNER_H1)
        begin
            h1_reg <= rd_data;
        end
        if (cmd.cap_en && cmd.cap_corner == CORNER_H2)
        begin
            h2_reg <= rd_data;
        end
        if (cmd.diff_en)
        begin
            a_reg  <= a_next;
            b_reg  <= b_next;
            f1_reg <= f1_next;
        end
        if (cmd.mul_en && !cmd.mul_second)
        begin
            p1_reg <= prod;
        end
        if (cmd.mul_en && cmd.mul_second)
        begin
            p2_reg <= prod;
        end
        if (cmd.sum_en)
        begin
            num_reg <= num_next;
        end
        if (cmd.abs_en)
        begin
            neg_reg <= neg_next;
            v_reg   <= v_next;
        end
        if (cmd.rcp_en)
        begin
            q_reg <= q_next;
        end
        if (cmd.load_out)
        begin
            height_reg   <= height_next;
            in_range_reg <= in_range_next;
        end
    end

    assign st.is_query = (func == FUNC_QUERY);
    assign st.in_range = range_ok;
    assign height      = height_reg;
    assign in_range    = in_range_reg;

    a_wr_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (int'(wr_addr) < DEPTH))
        else $error("grid write outside the memory");

    a_cell_index: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.cell_en && range_ok)
        |=> (int'(qx_reg) < GRID_POINTS - 1 && int'(qz_reg) < GRID_POINTS - 1))
        else $error("cell index past the last cell");

    a_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && !(qry_reg && inr_reg)) |=> (height_reg == '0 && !in_range_reg))
        else $error("nonzero height for a write or a miss");

endmodule

>>> sv/heightfield_triangle_height_query_top.sv
// Heightfield triangle height query. Keeps a GRID_POINTS x GRID_POINTS grid of signed q7.8
// vertex heights, 5 units apart and centred on the origin, in one memory of GRID_POINTS**2
// words with no clearing pass: a query must only touch vertices written since reset. A write
// word (func 0) stores one height and returns height 0, in_range 0; indexes past the grid
// are dropped. A query word (func 1) splits the cell under (pos_x, pos_z) on its diagonal and
// returns the chosen triangle's plane height, truncated toward zero and saturated; points off
// the grid return height 0, in_range 0. One word is worked at a time; an on-grid query steps
// through the four corner reads on the single read port and the multiplier shared by the two
// plane terms. A finished result sits in an output register, so the next word is taken while
// it waits; a stalled output only holds the following result back.
// depends on hftq_pkg, hftq_ctrl, hftq_dp
module heightfield_triangle_height_query_top #(
    parameter int GRID_POINTS = 21
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              func,
    input  logic signed [hftq_pkg::H_W-1:0]   pos_x,
    input  logic signed [hftq_pkg::H_W-1:0]   pos_z,
    input  logic [hftq_pkg::IDX_W-1:0]        grid_col,
    input  logic [hftq_pkg::IDX_W-1:0]        grid_row,
    input  logic signed [hftq_pkg::H_W-1:0]   height_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [hftq_pkg::H_W-1:0]   height,
    output logic                              in_range
);

    import hftq_pkg::*;

    cmd_t    cmd;
    status_t st;

    hftq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    hftq_dp #(
        .GRID_POINTS (GRID_POINTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .func         (func),
        .pos_x        (pos_x),
        .pos_z        (pos_z),
        .grid_col     (grid_col),
        .grid_row     (grid_row),
        .height_value (height_value),
        .height       (height),
        .in_range     (in_range)
    );

endmodule

>>> tb/hftq_tb_pkg.sv
// testbench package for the heightfield triangle height query block: the surface
// predictor with its own copy of the height grid, and the store of expected results
// depends on hftq_pkg
package hftq_tb_pkg;

    import hftq_pkg::*;

    localparam int GRID      = 21;
    localparam int CELL      = 1280;
    localparam int SPAN      = (GRID - 1) * CELL;
    localparam int HALF_SPAN = SPAN / 2;

    typedef struct {
        logic signed [H_W-1:0] height;
        logic                  in_range;
    } surface_result_t;

    class surface_sb;

        logic signed [H_W-1:0] grid_heights [GRID*GRID];
        surface_result_t       pending_results [$];
        int                    mismatches;

        function new();
            foreach (grid_heights[i])
                grid_heights[i] = '0;
            mismatches = 0;
        endfunction

        // plane height of the triangle under the point, zero when off the grid
        function surface_result_t surface_height(input logic signed [H_W-1:0] px,
                                                 input logic signed [H_W-1:0] pz);
            int              u, w, cx, cz, dx, dz;
            longint          h0, h1, h2, h3, num, v;
            surface_result_t r;
            r.height   = '0;
            r.in_range = 1'b0;
            u = int'(px) + HALF_SPAN;
            w = HALF_SPAN - int'(pz);
            if (u >= 0 && u < SPAN && w >= 0 && w < SPAN)
            begin
                cx = u / CELL;
                cz = w / CELL;
                dx = u - cx * CELL;
                dz = w - cz * CELL;
                h0 = grid_heights[cx * GRID + cz];
                h1 = grid_heights[(cx + 1) * GRID + cz];
                h2 = grid_heights[cx * GRID + cz + 1];
                h3 = grid_heights[(cx + 1) * GRID + cz + 1];
                // points on the diagonal go to the far triangle
                if (dx + dz < CELL)
                    num = (h0 - h1) * (CELL - dx) + (h2 - h0) * dz;
                else
                    num = (h2 - h3) * (CELL - dx) + (h3 - h1) * dz;
                v = h1 + num / CELL;
                if (v > H_MAX)
                    v = H_MAX;
                if (v < H_MIN)
                    v = H_MIN;
                r.height   = v[H_W-1:0];
                r.in_range = 1'b1;
            end
            return r;
        endfunction

        function void note_word(input func_t f,
                                input logic signed [H_W-1:0] px,
                                input logic signed [H_W-1:0] pz,
                                input logic [IDX_W-1:0] col,
                                input logic [IDX_W-1:0] row,
                                input logic signed [H_W-1:0] hv);
            surface_result_t r;
            r.height   = '0;
            r.in_range = 1'b0;
            if (f == FUNC_WRITE)
            begin
                if (int'(col) < GRID && int'(row) < GRID)
                    grid_heights[int'(col) * GRID + int'(row)] = hv;
            end
            else
                r = surface_height(px, pz);
            pending_results.push_back(r);
        endfunction

        function void check_result(input logic signed [H_W-1:0] h, input logic inr);
            surface_result_t e;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected, height %0d in_range %0b",
                         $time, h, inr);
                mismatches++;
                return;
            end
            e = pending_results.pop_front();
            if (h !== e.height)
            begin
                $display("%0t: height mismatch, expected %0d, got %0d", $time, e.height, h);
                mismatches++;
            end
            if (inr !== e.in_range)
            begin
                $display("%0t: in_range mismatch, expected %0b, got %0b",
                         $time, e.in_range, inr);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

    endclass

endpackage

>>> tb/tb_top.sv
// top of the heightfield triangle height query testbench: clock, reset, word driver,
// output stall pattern, monitor and watchdog
// depends on hftq_pkg, hftq_tb_pkg and heightfield_triangle_height_query_top
module tb_top;

    import hftq_pkg::*;
    import hftq_tb_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_WORDS = 450;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  func;
    logic signed [H_W-1:0] pos_x;
    logic signed [H_W-1:0] pos_z;
    logic [IDX_W-1:0]      grid_col;
    logic [IDX_W-1:0]      grid_row;
    logic signed [H_W-1:0] height_value;
    logic                  out_valid;
    logic                  out_stall;
    logic signed [H_W-1:0] height;
    logic                  in_range;

    surface_sb surface_check;
    bit        vert_set [GRID*GRID];
    int        burst_left;
    int        words_sent;
    int        quiet_cycles;
    int        stall_mode;
    int        stall_left;

    heightfield_triangle_height_query_top #(.GRID_POINTS(GRID)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .pos_x        (pos_x),
        .pos_z        (pos_z),
        .grid_col     (grid_col),
        .grid_row     (grid_row),
        .height_value (height_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .height       (height),
        .in_range     (in_range)
    );

    always #6 clk = ~clk;

    // receiver: stretches of no stall, light stall and heavy stall
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 80);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                surface_check.check_result(height, in_range);
            if (in_valid && !in_stall)
                surface_check.note_word(func_t'(func), pos_x, pos_z, grid_col, grid_row,
                                        height_value);
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input func_t f,
                             input logic [H_W-1:0] px,
                             input logic [H_W-1:0] pz,
                             input logic [IDX_W-1:0] col,
                             input logic [IDX_W-1:0] row,
                             input logic [H_W-1:0] hv);
        int gap;
        bit taken;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(0, 5);
            burst_left = $urandom_range(1, 30);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        func         <= f;
        pos_x        <= px;
        pos_z        <= pz;
        grid_col     <= col;
        grid_row     <= row;
        height_value <= hv;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !in_stall;
            @(negedge clk);
        end
        words_sent++;
    endtask

    function automatic logic [H_W-1:0] pick_height();
        case ($urandom_range(0, 9))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return '0;
            default: return H_W'($urandom);
        endcase
    endfunction

    function automatic int pick_offset();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return CELL - 1;
            2:       return CELL / 2;
            default: return $urandom_range(0, CELL - 1);
        endcase
    endfunction

    task automatic put_height(input int col, input int row, input logic [H_W-1:0] hv);
        send_word(FUNC_WRITE, H_W'($urandom), H_W'($urandom), IDX_W'(col), IDX_W'(row), hv);
        if (col < GRID && row < GRID)
            vert_set[col * GRID + row] = 1'b1;
    endtask

    // query word; any corner of the cell not yet written gets a height first
    task automatic probe(input logic signed [H_W-1:0] px, input logic signed [H_W-1:0] pz);
        int u, w, cx, cz, col, row;
        u = int'(px) + HALF_SPAN;
        w = HALF_SPAN - int'(pz);
        if (u >= 0 && u < SPAN && w >= 0 && w < SPAN)
        begin
            cx = u / CELL;
            cz = w / CELL;
            for (int k = 0; k < 4; k++)
            begin
                col = cx + (k & 1);
                row = cz + (k >> 1);
                if (!vert_set[col * GRID + row])
                    put_height(col, row, pick_height());
            end
        end
        send_word(FUNC_QUERY, px, pz, IDX_W'($urandom), IDX_W'($urandom), H_W'($urandom));
    endtask

    task automatic cell_probe(input int cx, input int cz, input int dx, input int dz);
        probe(H_W'(cx * CELL + dx - HALF_SPAN), H_W'(HALF_SPAN - (cz * CELL + dz)));
    endtask

    initial
    begin
        int cx, cz, dx, dz, u, w, first_random;
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        func         = FUNC_WRITE;
        pos_x        = '0;
        pos_z        = '0;
        grid_col     = '0;
        grid_row     = '0;
        height_value = '0;
        out_stall    = 1'b0;
        burst_left   = 0;
        words_sent   = 0;
        quiet_cycles = 0;
        stall_mode   = 0;
        stall_left   = 0;
        surface_check = new();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // extreme heights on the first cell
        put_height(0, 0, 16'h7fff);
        put_height(1, 0, 16'h8000);
        put_height(0, 1, 16'h8000);
        put_height(1, 1, 16'h7fff);
        cell_probe(0, 0, 0, 0);
        cell_probe(0, 0, CELL / 2, CELL / 2);
        cell_probe(0, 0, CELL - 1, CELL - 1);
        cell_probe(0, 0, CELL - 1, 0);
        cell_probe(0, 0, 0, CELL - 1);
        cell_probe(0, 0, 300, 200);
        // writes past the grid must leave the table alone
        put_height(GRID, 0, 16'h1234);
        put_height(0, GRID, 16'h4321);
        put_height(31, 31, 16'h5555);
        cell_probe(0, 0, 0, 0);
        // one step outside each edge, far edges exactly on the boundary
        probe(H_W'(-HALF_SPAN - 1), H_W'(HALF_SPAN));
        probe(H_W'(HALF_SPAN), '0);
        probe('0, H_W'(-HALF_SPAN));
        probe('0, H_W'(HALF_SPAN + 1));
        probe(16'sh8000, 16'sh8000);
        probe(16'sh7fff, 16'sh7fff);
        cell_probe(GRID - 2, GRID - 2, CELL - 1, CELL - 1);

        first_random = words_sent;
        while (words_sent - first_random < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 99)) inside
                [0:54]:
                begin
                    cx = $urandom_range(0, GRID - 2);
                    cz = $urandom_range(0, GRID - 2);
                    dx = pick_offset();
                    if ($urandom_range(0, 3) == 0)
                        dz = (CELL - dx) % CELL;
                    else
                        dz = pick_offset();
                    cell_probe(cx, cz, dx, dz);
                end
                [55:69]:
                    put_height($urandom_range(0, GRID - 1), $urandom_range(0, GRID - 1),
                               pick_height());
                [70:79]:
                begin
                    if ($urandom_range(0, 1))
                        put_height($urandom_range(GRID, 31), $urandom_range(0, 31),
                                   H_W'($urandom));
                    else
                        put_height($urandom_range(0, 31), $urandom_range(GRID, 31),
                                   H_W'($urandom));
                end
                [80:89]:
                    probe(H_W'($urandom), H_W'($urandom));
                default:
                begin
                    case ($urandom_range(0, 4))
                        0:       u = -1;
                        1:       u = 0;
                        2:       u = SPAN - 1;
                        3:       u = SPAN;
                        default: u = $urandom_range(0, SPAN - 1);
                    endcase
                    case ($urandom_range(0, 4))
                        0:       w = -1;
                        1:       w = 0;
                        2:       w = SPAN - 1;
                        3:       w = SPAN;
                        default: w = $urandom_range(0, SPAN - 1);
                    endcase
                    probe(H_W'(u - HALF_SPAN), H_W'(HALF_SPAN - w));
                end
            endcase
        end
        in_valid <= 1'b0;

        while (surface_check.outstanding() != 0)
            @(negedge clk);
        // this wait catches any stray result still to come
        repeat (20) @(negedge clk);
        if (surface_check.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
